// ----- hw/rtl/value_stack_with_dup_swap_defines.svh -----
`ifndef VALUE_STACK_WITH_DUP_SWAP_DEFINES_SVH
`define VALUE_STACK_WITH_DUP_SWAP_DEFINES_SVH

// concurrent check on clk, off while rst_n is low
`define VSDS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check on clk, also active during reset
`define VSDS_ASSERT_NR(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/vsds_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package vsds_pkg;

  localparam int STACK_DEPTH_DEF = 128;
  localparam int WORD_W = 64;
  localparam int MODE_W = 3;
  localparam int DEPTH_OUT_W = 8;
  localparam int OUT_DATA_W = 80;

  localparam logic [MODE_W-1:0] OP_PUSH  = 3'd0;
  localparam logic [MODE_W-1:0] OP_POP   = 3'd1;
  localparam logic [MODE_W-1:0] OP_DUP   = 3'd2;
  localparam logic [MODE_W-1:0] OP_SWAP  = 3'd3;
  localparam logic [MODE_W-1:0] OP_CLEAR = 3'd4;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_SHORT = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_FILL = 1'b1
  } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/vsds_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module vsds_ram #(
  parameter int DEPTH = vsds_pkg::STACK_DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [AW-1:0]               wr_addr,
  input  wire logic [vsds_pkg::WORD_W-1:0] wr_data,
  input  wire logic                        rd_en,
  input  wire logic [AW-1:0]               rd_addr,
  output logic      [vsds_pkg::WORD_W-1:0] rd_data
);

  logic [vsds_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/value_stack_with_dup_swap.sv -----
`timescale 1ns / 1ps
`default_nettype none
// output: the result word is registered, into the skid register instead while the output stalls
// input: push, dup, clear and unused modes take no fill state; pop and swap with two or
//   more entries enter it, which reloads the cached top from the one ram read port
// reset: depth goes to zero and the output is emptied; the entry ram is not cleared

module value_stack_with_dup_swap #(
  parameter int STACK_DEPTH = vsds_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [vsds_pkg::WORD_W-1:0]     in_tdata,   // push_word
  input  wire logic [vsds_pkg::MODE_W-1:0]     in_tuser,   // mode
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic      [vsds_pkg::OUT_DATA_W-1:0] out_tdata   // popped_word, status, depth_now
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int PAD_W = vsds_pkg::OUT_DATA_W - vsds_pkg::WORD_W - 2 - vsds_pkg::DEPTH_OUT_W;

  vsds_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [vsds_pkg::WORD_W-1:0] top_r, top_nxt;
  logic swap_r, swap_nxt;
  logic out_valid_r, skid_valid_r;
  logic [vsds_pkg::OUT_DATA_W-1:0] out_data_r, skid_data_r;

  logic acc;
  logic [CW-1:0] n_m1, n_m2;
  logic [vsds_pkg::WORD_W-1:0] op_popped;
  vsds_pkg::status_t op_status;
  logic [CW-1:0] op_n;
  logic [vsds_pkg::WORD_W-1:0] op_top;
  logic op_wr, op_rd, op_swap;
  logic [CW+7:0] n_ext;
  logic [vsds_pkg::OUT_DATA_W-1:0] res_data;

  logic ram_wr_en, ram_rd_en;
  logic [AW-1:0] ram_wr_addr, ram_rd_addr;
  logic [vsds_pkg::WORD_W-1:0] ram_rd_data;

  assign n_m1 = n_r - CW'(1);
  assign n_m2 = n_r - CW'(2);

  // ram holds every entry below the cached top
  vsds_ram #(
    .DEPTH(STACK_DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(top_r),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  always_comb begin
    op_popped = '0;
    op_status = vsds_pkg::ST_OK;
    op_n      = n_r;
    op_top    = top_r;
    op_wr     = 1'b0;
    op_rd     = 1'b0;
    op_swap   = 1'b0;
    case (in_tuser)
      vsds_pkg::OP_PUSH: begin
        if (n_r < CW'(STACK_DEPTH)) begin
          op_n   = n_r + CW'(1);
          op_top = in_tdata;
          op_wr  = (n_r != '0);
        end else begin
          op_status = vsds_pkg::ST_FULL;
        end
      end
      vsds_pkg::OP_POP: begin
        if (n_r != '0) begin
          op_popped = top_r;
          op_n      = n_m1;
          op_rd     = (n_r >= CW'(2));
        end else begin
          op_status = vsds_pkg::ST_EMPTY;
        end
      end
      vsds_pkg::OP_DUP: begin
        if (n_r == '0) begin
          op_status = vsds_pkg::ST_EMPTY;
        end else if (n_r >= CW'(STACK_DEPTH)) begin
          op_status = vsds_pkg::ST_FULL;
        end else begin
          op_n  = n_r + CW'(1);
          op_wr = 1'b1;
        end
      end
      vsds_pkg::OP_SWAP: begin
        if (n_r >= CW'(2)) begin
          op_rd   = 1'b1;
          op_swap = 1'b1;
        end else begin
          op_status = vsds_pkg::ST_SHORT;
        end
      end
      vsds_pkg::OP_CLEAR: begin
        op_n = '0;
      end
      default: begin
      end
    endcase
  end

  assign n_ext    = {8'b0, op_n};
  assign res_data = {PAD_W'(0), n_ext[7:0], op_status, op_popped};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vsds_pkg::S_IDLE: begin
        if (acc && op_rd) begin
          state_nxt = vsds_pkg::S_FILL;
        end
      end
      vsds_pkg::S_FILL: begin
        state_nxt = vsds_pkg::S_IDLE;
      end
      default: begin
        state_nxt = vsds_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready   = (state_r == vsds_pkg::S_IDLE) && !skid_valid_r;
    acc         = in_tvalid && in_tready;
    ram_rd_en   = acc && op_rd;
    ram_rd_addr = n_m2[AW-1:0];
    if (state_r == vsds_pkg::S_FILL) begin
      ram_wr_en   = swap_r;
      ram_wr_addr = n_m2[AW-1:0];
      top_nxt     = ram_rd_data;
      n_nxt       = n_r;
      swap_nxt    = 1'b0;
    end else begin
      ram_wr_en   = acc && op_wr;
      ram_wr_addr = n_m1[AW-1:0];
      top_nxt     = acc ? op_top : top_r;
      n_nxt       = acc ? op_n : n_r;
      swap_nxt    = acc && op_swap;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= vsds_pkg::S_IDLE;
      n_r          <= '0;
      swap_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      swap_r  <= swap_nxt;
      if (acc) begin
        if (!out_valid_r || out_tready) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (out_valid_r && out_tready) begin
        if (skid_valid_r) begin
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    if (acc) begin
      if (!out_valid_r || out_tready) begin
        out_data_r <= res_data;
      end else begin
        skid_data_r <= res_data;
      end
    end else if (out_valid_r && out_tready && skid_valid_r) begin
      out_data_r <= skid_data_r;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/vsds_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "value_stack_with_dup_swap_defines.svh"

module vsds_chk #(
  parameter int STACK_DEPTH = vsds_pkg::STACK_DEPTH_DEF
) (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [vsds_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam logic [7:0] FULL_D = 8'(STACK_DEPTH % 256);

  logic [vsds_pkg::WORD_W-1:0] popped;
  logic [1:0] status;
  logic [7:0] depth;
  logic out_stall;
  logic is_empty, is_full, is_short;

  assign popped = out_tdata[63:0];
  assign status = out_tdata[65:64];
  assign depth  = out_tdata[73:66];

  assign out_stall = out_tvalid && !out_tready;
  assign is_empty  = out_tvalid && (status == vsds_pkg::ST_EMPTY);
  assign is_full   = out_tvalid && (status == vsds_pkg::ST_FULL);
  assign is_short  = out_tvalid && (status == vsds_pkg::ST_SHORT);

  `VSDS_ASSERT_NR(a_reset_empty, !rst_n |=> !out_tvalid, "output word valid after reset")
  `VSDS_ASSERT(a_hold, out_stall |=> out_tvalid && $stable(out_tdata), "stalled word changed")
  `VSDS_ASSERT(a_empty, is_empty |-> popped == '0 && depth == '0, "empty status with data")
  `VSDS_ASSERT(a_full, is_full |-> popped == '0 && depth == FULL_D, "full status, wrong depth")
  `VSDS_ASSERT(a_short, is_short |-> popped == '0 && depth < 8'd2, "short status, deep stack")

endmodule

bind value_stack_with_dup_swap vsds_chk #(
  .STACK_DEPTH(STACK_DEPTH)
) u_vsds_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

`default_nettype wire
